// ===== design/positional_char_list_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positional_char_list block
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_CHAR_LIST_DEFINES_SVH
`define POSITIONAL_CHAR_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define PCL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcl: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcl: next-cycle check failed");

`else

`define PCL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/pcl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared constants, codes and types of the positional character list.
// ----------------------------------------------------------------------------
`default_nettype none

package pcl_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int STAT_W   = 2;
    localparam int OUTN_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT
    } t_cell_op;

    typedef struct packed {
        logic             do_app;
        logic             do_ins;
        logic             do_del;
        logic             do_search;
        t_status          status;
        logic [CNT_W-1:0] next_count;
    } t_ctl;

    typedef struct packed {
        t_status           status;
        logic [OUTN_W-1:0] found;
        logic [OUTN_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

// ===== design/pcl_cell.sv =====
// ----------------------------------------------------------------------------
// pcl_cell
// One list slot: holds a byte, loads, shifts from a neighbor, compares.
// ----------------------------------------------------------------------------
`default_nettype none

module pcl_cell (
    input  wire                            i_clk,
    input  pcl_pkg::t_cell_op              i_op,
    input  wire  [pcl_pkg::BYTE_W-1:0]     i_load,
    input  wire  [pcl_pkg::BYTE_W-1:0]     i_prev,
    input  wire  [pcl_pkg::BYTE_W-1:0]     i_next,
    input  wire  [pcl_pkg::BYTE_W-1:0]     i_key,
    output logic [pcl_pkg::BYTE_W-1:0]     o_data,
    output logic                           o_match
);
    import pcl_pkg::*;

    logic [BYTE_W-1:0] r_data;
    logic [BYTE_W-1:0] n_data;

    always_comb begin
        unique case (i_op)
            CELL_LOAD:      n_data = i_load;
            CELL_FROM_PREV: n_data = i_prev;
            CELL_FROM_NEXT: n_data = i_next;
            default:        n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

`default_nettype wire

// ===== design/pcl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcl_ctrl
// Command decode: range and full checks, status and next item count.
// ----------------------------------------------------------------------------
`default_nettype none

module pcl_ctrl (
    input  wire  [pcl_pkg::CMD_W-1:0]  i_command,
    input  wire  [pcl_pkg::POS_W-1:0]  i_position,
    input  wire  [pcl_pkg::CNT_W-1:0]  i_count,
    output pcl_pkg::t_ctl              o_ctl
);
    import pcl_pkg::*;

    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;
    logic             w_full;
    logic             w_pos_ok;

    assign w_pos    = CMP_W'(i_position);
    assign w_cnt    = CMP_W'(i_count);
    assign w_full   = (w_cnt >= CMP_W'(CAPACITY));
    assign w_pos_ok = (w_pos != '0) && (w_pos <= w_cnt);

    always_comb begin
        o_ctl            = '0;
        o_ctl.status     = ST_DONE;
        o_ctl.next_count = i_count;
        unique case (i_command)
            CMD_APPEND: begin
                if (w_full) begin
                    o_ctl.status = ST_FULL;
                end else begin
                    o_ctl.do_app     = 1'b1;
                    o_ctl.next_count = i_count + CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                if (!w_pos_ok) begin
                    o_ctl.status = ST_RANGE;
                end else if (w_full) begin
                    o_ctl.status = ST_FULL;
                end else begin
                    o_ctl.do_ins     = 1'b1;
                    o_ctl.next_count = i_count + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (!w_pos_ok) begin
                    o_ctl.status = ST_RANGE;
                end else begin
                    o_ctl.do_del     = 1'b1;
                    o_ctl.next_count = i_count - CNT_W'(1);
                end
            end
            CMD_SEARCH: begin
                o_ctl.do_search = 1'b1;
            end
            CMD_CLEAR: begin
                o_ctl.next_count = '0;
            end
            default: begin
                o_ctl.next_count = i_count;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/positional_char_list.sv =====
// ----------------------------------------------------------------------------
// positional_char_list
// Bounded ordered byte list with append, insert, delete, search and clear.
// ----------------------------------------------------------------------------
// The list lives in a row of byte cells: an insert or delete shifts every
// affected cell by one place toward its neighbor in the same edge, while a
// search compares all cells at once and a priority encoder picks the first
// match. One command can be taken in every cycle while the input is not
// stalled; its result goes into the output register, or into the one-entry
// skid stage behind it while the output side holds off, so the input stalls
// only after the output side has held off for two results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "positional_char_list_defines.svh"

module positional_char_list (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [pcl_pkg::CMD_W-1:0]        i_command,
    input  wire  [pcl_pkg::BYTE_W-1:0]       i_data_byte,
    input  wire  [pcl_pkg::POS_W-1:0]        i_position,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [pcl_pkg::STAT_W-1:0]       o_status,
    output logic [pcl_pkg::OUTN_W-1:0]       o_found_position,
    output logic [pcl_pkg::OUTN_W-1:0]       o_item_count
);
    import pcl_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic              r_skid_valid;
    t_result           r_out;
    t_result           r_skid;

    t_ctl              w_ctl;
    logic              w_fire;
    logic              w_take;
    logic [CMP_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_cnt;
    logic [CMP_W-1:0]  w_found;
    t_result           w_res;

    logic [BYTE_W-1:0] w_data  [CAPACITY];
    logic              w_match [CAPACITY];

    assign w_fire = i_in_valid && !r_skid_valid;
    assign w_take = r_out_valid && !i_out_stall;
    assign w_pos  = CMP_W'(i_position);
    assign w_cnt  = CMP_W'(r_count);

    pcl_ctrl u_ctrl (
        .i_command  (i_command),
        .i_position (i_position),
        .i_count    (r_count),
        .o_ctl      (w_ctl)
    );

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [CMP_W-1:0] IDX    = CMP_W'(gi);
        localparam logic [CMP_W-1:0] IDX_P1 = CMP_W'(gi + 1);
        t_cell_op          w_op;
        logic [BYTE_W-1:0] w_prev;
        logic [BYTE_W-1:0] w_next;

        if (gi == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_data[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_next
            assign w_next = w_data[gi+1];
        end

        always_comb begin
            w_op = CELL_HOLD;
            if (w_fire) begin
                if (w_ctl.do_app && (IDX == w_cnt)) begin
                    w_op = CELL_LOAD;
                end else if (w_ctl.do_ins && (IDX_P1 == w_pos)) begin
                    w_op = CELL_LOAD;
                end else if (w_ctl.do_ins && (IDX >= w_pos) && (IDX <= w_cnt)) begin
                    // open the gap: later items move one place back
                    w_op = CELL_FROM_PREV;
                end else if (w_ctl.do_del && (IDX_P1 >= w_pos) && (IDX_P1 < w_cnt)) begin
                    // close the gap over the deleted slot
                    w_op = CELL_FROM_NEXT;
                end
            end
        end

        pcl_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_load  (i_data_byte),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_key   (i_data_byte),
            .o_data  (w_data[gi]),
            .o_match (w_match[gi])
        );
    end

    // first occupied slot that matches; scan from the back so the lowest wins
    always_comb begin
        w_found = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (w_match[k] && (CMP_W'(k) < w_cnt)) begin
                w_found = CMP_W'(k + 1);
            end
        end
    end

    always_comb begin
        w_res.status = w_ctl.status;
        w_res.found  = w_ctl.do_search ? OUTN_W'(w_found) : '0;
        w_res.count  = OUTN_W'(w_ctl.next_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_fire) begin
            r_count <= w_ctl.next_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_fire) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_fire) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_in_stall       = r_skid_valid;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_position = r_out.found;
    assign o_item_count     = r_out.count;

    `PCL_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `PCL_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `PCL_ASSERT_SAME(a_full_at_capacity, i_clk, i_rst_n, r_out_valid && (r_out.status == ST_FULL), r_out.count == OUTN_W'(CAPACITY))
    `PCL_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, w_fire && (i_command == CMD_CLEAR), r_count == '0)

endmodule

`default_nettype wire
